// File: rtl/two_class_priority_queue_defines.svh
// Assertion macros shared by the queue RTL.
`ifndef TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH
`define TWO_CLASS_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/tcpq_pkg.sv
`timescale 1ns / 1ps

package tcpq_pkg;

	localparam int VALUE_W = 32;
	localparam int CMD_W   = 2;
	localparam int OCC_W   = 5;

	// threshold after reset
	localparam logic signed [VALUE_W-1:0] THRESHOLD_RESET = 32'sd60;

	typedef enum logic [CMD_W-1:0] {
		CMD_PLAIN  = 2'd0,
		CMD_PRIO   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic ins;       // insert goes ahead this cycle
		logic prio_ins;  // insert is priority class (value at or above threshold)
		logic pop;       // head leaves this cycle
	} cell_ctrl_t;

endpackage

// File: rtl/tcpq_cell.sv
`timescale 1ns / 1ps

module tcpq_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  logic                                 clk,
	input  tcpq_pkg::cell_ctrl_t                 ctrl,
	input  logic [CW-1:0]                        count,
	input  logic signed [tcpq_pkg::VALUE_W-1:0]  thr,
	input  logic signed [tcpq_pkg::VALUE_W-1:0]  new_value,
	input  logic signed [tcpq_pkg::VALUE_W-1:0]  left_value,
	input  logic signed [tcpq_pkg::VALUE_W-1:0]  right_value,
	input  logic                                 stop_in,
	output logic                                 stop_out,
	output logic signed [tcpq_pkg::VALUE_W-1:0]  value_q
);
	import tcpq_pkg::*;

	logic occ;
	logic run;
	logic stop_here;

	// this cell holds a live entry
	assign occ = CW'(INDEX) < count;

	// insert point moves past this cell while it belongs to the leading run
	assign run       = occ && (!ctrl.prio_ins || (value_q >= thr));
	assign stop_here = !stop_in && !run;
	assign stop_out  = stop_in || !run;

	// shift right on insert past the slot, shift left on pop
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (stop_here) begin
				value_q <= new_value;
			end else if (stop_in) begin
				value_q <= left_value;
			end
		end else if (ctrl.pop) begin
			value_q <= right_value;
		end
	end

endmodule

// File: rtl/two_class_priority_queue.sv
`timescale 1ns / 1ps
//  channel   | ports                                          | handshake
//  ----------+------------------------------------------------+---------------------
//  item in   | cmd, value                                     | start && !busy
//  result    | removed_value, removed_valid, insert_dropped,  | done, one cycle
//            | occupancy                                      |
//  config    | cfg_wdata                                      | cfg_we
//
// One item per cycle: the row of cells shifts or inserts in the accept cycle
// and the result shows on done in the following cycle. busy stays low.
// The insert slot is found by a ripple through the cells, whose length
// grows with DEPTH. arst_n clears the count, the threshold (to 60) and done;
// cell contents are not reset. Results cannot be stalled.

`include "two_class_priority_queue_defines.svh"

module two_class_priority_queue #(
	parameter int DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [tcpq_pkg::CMD_W-1:0]           cmd,
	input  logic signed [tcpq_pkg::VALUE_W-1:0]  value,
	input  logic                                 cfg_we,
	input  logic signed [tcpq_pkg::VALUE_W-1:0]  cfg_wdata,
	output logic                                 done,
	output logic signed [tcpq_pkg::VALUE_W-1:0]  removed_value,
	output logic                                 removed_valid,
	output logic                                 insert_dropped,
	output logic [tcpq_pkg::OCC_W-1:0]           occupancy
);
	import tcpq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_d;
	logic signed [VALUE_W-1:0]    thr_q;
	logic                         accept;
	logic                         is_ins;
	logic                         full;
	logic                         empty;
	cell_ctrl_t                   ctrl;
	logic [DEPTH:0]               stop;
	logic signed [VALUE_W-1:0]    cell_value [DEPTH];

	logic                         done_q;
	logic signed [VALUE_W-1:0]    removed_value_q;
	logic                         removed_valid_q;
	logic                         insert_dropped_q;
	logic [OCC_W-1:0]             occupancy_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = count_q >= CW'(DEPTH);
	assign empty  = count_q == '0;
	assign is_ins = (cmd == CMD_PLAIN) || (cmd == CMD_PRIO);

	// control broadcast to the cells
	always_comb begin
		ctrl.ins      = accept && is_ins && !full;
		ctrl.prio_ins = (cmd == CMD_PRIO) && (value >= thr_q);
		ctrl.pop      = accept && (cmd == CMD_REMOVE) && !empty;
	end

	// next count
	always_comb begin
		count_d = count_q;
		if (ctrl.ins) begin
			count_d = count_q + CW'(1);
		end else if (ctrl.pop) begin
			count_d = count_q - CW'(1);
		end
	end

	// row of cells, head at index 0
	assign stop[0] = 1'b0;
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_v;
		logic signed [VALUE_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = value;
		end else begin : g_left
			assign left_v = cell_value[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_right
			assign right_v = cell_value[i+1];
		end
		tcpq_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.thr         (thr_q),
			.new_value   (value),
			.left_value  (left_v),
			.right_value (right_v),
			.stop_in     (stop[i]),
			.stop_out    (stop[i+1]),
			.value_q     (cell_value[i])
		);
	end

	// count and threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			thr_q   <= THRESHOLD_RESET;
		end else begin
			count_q <= count_d;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			removed_value_q  <= ctrl.pop ? cell_value[0] : '0;
			removed_valid_q  <= ctrl.pop;
			insert_dropped_q <= is_ins && full;
			occupancy_q      <= OCC_W'(count_d);
		end
	end

	assign done           = done_q;
	assign removed_value  = removed_value_q;
	assign removed_valid  = removed_valid_q;
	assign insert_dropped = insert_dropped_q;
	assign occupancy      = occupancy_q;

	// checks
	`TCPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`TCPQ_ASSERT_NOW(a_result_excl, done_q, !(removed_valid_q && insert_dropped_q),
		"remove and drop in one result")
	`TCPQ_ASSERT_NEXT(a_drop_full, accept && is_ins && full,
		done_q && insert_dropped_q && (count_q == $past(count_q)), "full insert not dropped")
	`TCPQ_ASSERT_NEXT(a_pop_count, ctrl.pop,
		removed_valid_q && (count_q == $past(count_q) - CW'(1)), "pop count mismatch")

endmodule

// File: tb/sv/two_class_priority_queue_tb.sv
`timescale 1ns / 1ps

module two_class_priority_queue_tb;
	import tcpq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int MAX_REPORTS = 10;

	// one input item
	typedef struct {
		cmd_t                       cmd;
		logic signed [VALUE_W-1:0]  value;
	} queue_item_t;

	// one response of the queue
	typedef struct {
		logic signed [VALUE_W-1:0]  removed_value;
		logic                       removed_valid;
		logic                       insert_dropped;
		logic [OCC_W-1:0]           occupancy;
	} queue_response_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [CMD_W-1:0]           cmd = CMD_NOP;
	logic signed [VALUE_W-1:0]  value = '0;
	logic                       cfg_we = 1'b0;
	logic signed [VALUE_W-1:0]  cfg_wdata = '0;
	logic                       done;
	logic signed [VALUE_W-1:0]  removed_value;
	logic                       removed_valid;
	logic                       insert_dropped;
	logic [OCC_W-1:0]           occupancy;

	queue_item_t                pending_items[$];
	queue_response_t            awaited_responses[$];
	int                         items_outstanding = 0;
	int                         mismatches = 0;
	logic                       item_taken = 1'b0;
	int                         burst_left = 0;
	int                         gap_left = 0;

	// shadow copy of the queue contents and threshold
	logic signed [VALUE_W-1:0]  shadow_entries[$];
	logic signed [VALUE_W-1:0]  shadow_threshold = THRESHOLD_RESET;
	logic signed [VALUE_W-1:0]  phase_threshold = THRESHOLD_RESET;

	two_class_priority_queue #(
		.DEPTH(QUEUE_DEPTH)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.value          (value),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.done           (done),
		.removed_value  (removed_value),
		.removed_valid  (removed_valid),
		.insert_dropped (insert_dropped),
		.occupancy      (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// apply one item to the shadow queue and return the response it causes
	function automatic queue_response_t apply_to_shadow(cmd_t op, logic signed [VALUE_W-1:0] v);
		queue_response_t r;
		int slot;
		r.removed_value = '0;
		r.removed_valid = 1'b0;
		r.insert_dropped = 1'b0;
		case (op)
			CMD_PLAIN, CMD_PRIO: begin
				if (shadow_entries.size() >= QUEUE_DEPTH) begin
					r.insert_dropped = 1'b1;
				end else begin
					slot = shadow_entries.size();
					// priority class goes behind the leading priority run
					if (op == CMD_PRIO && v >= shadow_threshold) begin
						slot = 0;
						while (slot < shadow_entries.size() && shadow_entries[slot] >= shadow_threshold)
							slot++;
					end
					shadow_entries.insert(slot, v);
				end
			end
			CMD_REMOVE: begin
				if (shadow_entries.size() > 0) begin
					r.removed_value = shadow_entries.pop_front();
					r.removed_valid = 1'b1;
				end
			end
			default: ;
		endcase
		r.occupancy = OCC_W'(shadow_entries.size());
		return r;
	endfunction

	// driver: bursts of items with random gaps between them
	always @(negedge clk) begin
		queue_item_t nxt;
		if (!start || item_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_items.size() > 0) begin
				nxt = pending_items.pop_front();
				start <= 1'b1;
				cmd <= nxt.cmd;
				value <= nxt.value;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and predictor: check the response first, then take the new item
	always @(posedge clk) begin
		queue_response_t want;
		item_taken = 1'b0;
		if (arst_n) begin
			if (done) begin
				if (awaited_responses.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("response with nothing awaited: value %0d valid %0b dropped %0b occ %0d",
							removed_value, removed_valid, insert_dropped, occupancy);
				end else begin
					want = awaited_responses.pop_front();
					if (removed_value !== want.removed_value || removed_valid !== want.removed_valid ||
						insert_dropped !== want.insert_dropped || occupancy !== want.occupancy) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: exp value %0d valid %0b dropped %0b occ %0d, got value %0d valid %0b dropped %0b occ %0d",
								want.removed_value, want.removed_valid, want.insert_dropped, want.occupancy,
								removed_value, removed_valid, insert_dropped, occupancy);
					end
				end
			end
			if (start && !busy) begin
				item_taken = 1'b1;
				awaited_responses.push_back(apply_to_shadow(cmd_t'(cmd), value));
				items_outstanding--;
			end
			if (cfg_we)
				shadow_threshold = cfg_wdata;
		end
	end

	task automatic queue_item(cmd_t op, logic signed [VALUE_W-1:0] v);
		queue_item_t it;
		it.cmd = op;
		it.value = v;
		pending_items.push_back(it);
		items_outstanding++;
	endtask

	// every item accepted and every response back
	task automatic wait_for_drain();
		while (items_outstanding != 0 || awaited_responses.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_threshold(logic signed [VALUE_W-1:0] thr);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= thr;
		@(negedge clk);
		cfg_we <= 1'b0;
		phase_threshold = thr;
	endtask

	// values clustered around the threshold, the extremes, or anything
	function automatic logic signed [VALUE_W-1:0] pick_value(logic signed [VALUE_W-1:0] thr);
		logic signed [VALUE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = thr;
			1: v = thr - 1;
			2: v = thr + 1;
			3: v = {1'b1, {(VALUE_W-1){1'b0}}};
			4: v = {1'b0, {(VALUE_W-1){1'b1}}};
			5: v = thr + $signed($urandom_range(0, 16)) - 8;
			6: v = $signed($urandom_range(0, 200)) - 100;
			default: v = $urandom();
		endcase
		return v;
	endfunction

	// stimulus
	initial begin
		logic signed [VALUE_W-1:0] thr_list[8];
		int insert_pct[8];
		int per_phase;
		int taken_items;
		int r;

		thr_list = '{THRESHOLD_RESET, {1'b1, {(VALUE_W-1){1'b0}}}, {1'b0, {(VALUE_W-1){1'b1}}},
			32'sd0, -32'sd1, 32'sd0, 32'sd0, THRESHOLD_RESET};
		thr_list[5] = $urandom();
		thr_list[6] = $signed($urandom_range(0, 200)) - 100;
		insert_pct = '{70, 30, 50, 60, 40, 75, 25, 55};
		per_phase = 160;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty remove, nop, class placement, extremes, full queue
		queue_item(CMD_REMOVE, 32'sd5);
		queue_item(CMD_NOP, 32'sd7);
		queue_item(CMD_PLAIN, {1'b1, {(VALUE_W-1){1'b0}}});
		queue_item(CMD_PRIO, 32'sd60);
		queue_item(CMD_PRIO, 32'sd61);
		queue_item(CMD_PRIO, 32'sd59);
		queue_item(CMD_PLAIN, {1'b0, {(VALUE_W-1){1'b1}}});
		queue_item(CMD_PRIO, {1'b0, {(VALUE_W-1){1'b1}}});
		queue_item(CMD_PRIO, {1'b1, {(VALUE_W-1){1'b0}}});
		queue_item(CMD_PLAIN, 32'sd0);
		queue_item(CMD_PLAIN, -32'sd1);
		queue_item(CMD_PRIO, 32'sh7ffffffe);
		queue_item(CMD_PLAIN, 32'sd1);
		queue_item(CMD_PRIO, 32'sd59);
		queue_item(CMD_PLAIN, 32'sd60);
		queue_item(CMD_PRIO, -32'sd60);
		queue_item(CMD_PRIO, 32'sh55555555);
		queue_item(CMD_PLAIN, 32'shAAAAAAAA);
		queue_item(CMD_PLAIN, 32'sd3);
		queue_item(CMD_PRIO, 32'sd100);
		queue_item(CMD_NOP, -32'sd1);
		queue_item(CMD_REMOVE, 32'sd0);
		queue_item(CMD_REMOVE, -32'sd1);
		queue_item(CMD_REMOVE, 32'sd0);
		wait_for_drain();

		// random phases, each under the threshold from its entry of thr_list
		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0)
				write_threshold(thr_list[ph]);
			taken_items = 0;
			while (taken_items < per_phase) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					queue_item(CMD_NOP, $urandom());
				end else begin
					taken_items++;
					if (r < 3 + insert_pct[ph])
						queue_item(($urandom_range(0, 4) < 3) ? CMD_PRIO : CMD_PLAIN,
							pick_value(phase_threshold));
					else
						queue_item(CMD_REMOVE, $urandom());
				end
			end
			wait_for_drain();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0 && awaited_responses.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tcpq_pkg.sv
rtl/tcpq_cell.sv
rtl/two_class_priority_queue.sv
tb/sv/two_class_priority_queue_tb.sv
